// File: src/cda_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and calendar helpers for the calendar date adder.
// No dependencies; imported by calendar_date_adder_core and its testbench.
package cda_pkg;

   // unit selector codes (op field)
   localparam logic [2:0] OpDay        = 3'd0;
   localparam logic [2:0] OpWeek       = 3'd1;
   localparam logic [2:0] OpMonth      = 3'd2;
   localparam logic [2:0] OpYear       = 3'd3;
   localparam logic [2:0] OpDecade     = 3'd4;
   localparam logic [2:0] OpCentury    = 3'd5;
   localparam logic [2:0] OpMillennium = 3'd6;

   // status codes
   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusInvalid  = 2'd1;
   localparam logic [1:0] StatusOverflow = 2'd2;

   localparam logic [13:0] MaxYear = 14'd9999;

   // floor(y / 400) = (y * RecipMul) >> RecipShift, exact for 14-bit y
   localparam logic [12:0] RecipMul   = 13'd5243;
   localparam int          RecipShift = 21;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_QUOT   = 8'b0000_0010,
      ST_REM    = 8'b0000_0100,
      ST_CHECK  = 8'b0000_1000,
      ST_DAYS   = 8'b0001_0000,
      ST_MONTHS = 8'b0010_0000,
      ST_YEARS  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   // leap year from the year's remainder mod 400
   function automatic logic is_leap(input logic [8:0] r400);
      is_leap = (r400[1:0] == 2'd0) &&
                (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
   endfunction

   // month length; months outside 1..12 read as 0
   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
         4'd2:                                       days_in = leap ? 5'd29 : 5'd28;
         default:                                    days_in = 5'd0;
      endcase
   endfunction

endpackage

// File: src/calendar_date_adder_core.sv
`timescale 1ns / 1ps
// Gregorian date adder: sequencer around a shared month-advance unit.
// Depends on cda_pkg.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  req_    | in        | amount, start_day, start_month, start_year  | op
//  rsp_    | out       | end_day, end_month, end_year                | status
//
// An item passes the setup states ST_QUOT, ST_REM and ST_CHECK (mod-400 reduction, date
// check); an invalid date or unknown unit then goes straight to ST_FINISH. Otherwise it
// steps one month boundary per cycle (day/week units) or one month per cycle (month units),
// or adds once (year units), then waits in ST_FINISH for the output register. The longest
// item steps 32767 months. req_tready is high only when idle, so a new item is not accepted
// until the last one has left the sequencer. The result register holds an item until taken,
// so the next item may start while it waits; a finished item stalls until that register is free.
// Reset is synchronous and clears the sequencer and result valid.
module calendar_date_adder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // amount[14:0], start_day[19:15], start_month[23:20],
                                   // start_year[37:24], zero fill
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // end_day[4:0], end_month[8:5], end_year[22:9], zero fill
   output logic [1:0]  rsp_tuser   // status
);
   import cda_pkg::*;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [14:0] amt_ff, amt_in;
   logic [4:0]  d_ff, d_in;
   logic [3:0]  m_ff, m_in;
   logic [13:0] y_ff, y_in;
   logic [8:0]  r400_ff, r400_in;
   logic [5:0]  q_ff, q_in;
   logic [24:0] prod_ff, prod_in;
   logic [17:0] rem_ff, rem_in;
   logic [1:0]  st_ff, st_in;

   logic        ovalid_ff, ovalid_in;
   logic [4:0]  od_ff, od_in;
   logic [3:0]  om_ff, om_in;
   logic [13:0] oy_ff, oy_in;
   logic [1:0]  ost_ff, ost_in;

   logic        req_fire, rsp_fire;
   logic [26:0] quot_prod;
   logic [13:0] q_times;
   logic [13:0] r400_wide;
   logic [9:0]  mult;
   logic [4:0]  len_cur, len_adv;
   logic        valid_date;
   logic [18:0] day_sum;
   logic [5:0]  day_span;
   logic [25:0] year_sum;
   // shared month-advance unit
   logic [3:0]  m_adv;
   logic [13:0] y_adv;
   logic [8:0]  r400_adv;
   logic        adv_ovf;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {1'b0, oy_ff, om_ff, od_ff};
   assign rsp_tuser  = ost_ff;

   // reciprocal multiply for y / 400, then remainder
   assign quot_prod = {13'd0, y_ff} * {14'd0, RecipMul};
   assign q_times   = {8'd0, q_ff} * 14'd400;
   assign r400_wide = y_ff - q_times;

   // year-unit multiplier
   always_comb begin
      unique case (op_ff)
         OpDecade:     mult = 10'd10;
         OpCentury:    mult = 10'd100;
         OpMillennium: mult = 10'd1000;
         default:      mult = 10'd1;
      endcase
   end

   // advance one month, rolling the year and its mod-400 remainder
   always_comb begin
      adv_ovf  = 1'b0;
      m_adv    = m_ff + 4'd1;
      y_adv    = y_ff;
      r400_adv = r400_ff;
      if (m_ff == 4'd12) begin
         m_adv    = 4'd1;
         adv_ovf  = (y_ff >= MaxYear);
         y_adv    = y_ff + 14'd1;
         r400_adv = (r400_ff == 9'd399) ? 9'd0 : r400_ff + 9'd1;
      end
   end

   assign len_cur    = days_in(m_ff, is_leap(r400_ff));
   assign len_adv    = days_in(m_adv, is_leap(r400_adv));
   assign valid_date = (m_ff >= 4'd1) && (m_ff <= 4'd12) && (y_ff >= 14'd1) &&
                       (y_ff <= MaxYear) && (d_ff != 5'd0) && (d_ff <= len_cur);
   assign day_sum    = {14'd0, d_ff} + {1'b0, rem_ff};
   assign day_span   = {1'b0, len_cur} - {1'b0, d_ff} + 6'd1;
   assign year_sum   = {12'd0, y_ff} + {1'b0, prod_ff};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      amt_in    = amt_ff;
      d_in      = d_ff;
      m_in      = m_ff;
      y_in      = y_ff;
      r400_in   = r400_ff;
      q_in      = q_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      st_in     = st_ff;
      ovalid_in = ovalid_ff && !rsp_fire;
      od_in     = od_ff;
      om_in     = om_ff;
      oy_in     = oy_ff;
      ost_in    = ost_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               amt_in   = req_tdata[14:0];
               d_in     = req_tdata[19:15];
               m_in     = req_tdata[23:20];
               y_in     = req_tdata[37:24];
               st_in    = StatusOk;
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            q_in     = quot_prod[RecipShift +: 6];
            state_in = ST_REM;
         end
         ST_REM: begin
            r400_in  = r400_wide[8:0];
            prod_in  = {10'd0, amt_ff} * {15'd0, mult};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!valid_date) begin
               d_in     = 5'd0;
               m_in     = 4'd0;
               y_in     = 14'd0;
               st_in    = StatusInvalid;
               state_in = ST_FINISH;
            end else begin
               priority if (op_ff == OpDay || op_ff == OpWeek) begin
                  rem_in   = (op_ff == OpWeek) ?
                             ({amt_ff, 3'd0} - {3'd0, amt_ff}) : {3'd0, amt_ff};
                  state_in = ST_DAYS;
               end else if (op_ff == OpMonth) begin
                  rem_in   = {3'd0, amt_ff};
                  state_in = ST_MONTHS;
               end else if (op_ff == OpYear || op_ff == OpDecade ||
                            op_ff == OpCentury || op_ff == OpMillennium) begin
                  state_in = ST_YEARS;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DAYS: begin
            // one month boundary per cycle
            if (rem_ff == 18'd0) begin
               state_in = ST_FINISH;
            end else if (day_sum <= {14'd0, len_cur}) begin
               d_in     = day_sum[4:0];
               rem_in   = 18'd0;
               state_in = ST_FINISH;
            end else if (adv_ovf) begin
               d_in     = 5'd31;
               m_in     = 4'd12;
               y_in     = MaxYear;
               st_in    = StatusOverflow;
               state_in = ST_FINISH;
            end else begin
               rem_in  = rem_ff - {12'd0, day_span};
               d_in    = 5'd1;
               m_in    = m_adv;
               y_in    = y_adv;
               r400_in = r400_adv;
            end
         end
         ST_MONTHS: begin
            // one month per cycle, clamping the day each step
            if (rem_ff == 18'd0) begin
               state_in = ST_FINISH;
            end else if (adv_ovf) begin
               d_in     = 5'd31;
               m_in     = 4'd12;
               y_in     = MaxYear;
               st_in    = StatusOverflow;
               state_in = ST_FINISH;
            end else begin
               rem_in  = rem_ff - 18'd1;
               m_in    = m_adv;
               y_in    = y_adv;
               r400_in = r400_adv;
               if (d_ff > len_adv) d_in = len_adv;
            end
         end
         ST_YEARS: begin
            if (year_sum > {12'd0, MaxYear}) begin
               y_in  = MaxYear;
               st_in = StatusOverflow;
            end else begin
               y_in = year_sum[13:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hand over once the result register is free
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               od_in     = d_ff;
               om_in     = m_ff;
               oy_in     = y_ff;
               ost_in    = st_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      amt_ff  <= amt_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      r400_ff <= r400_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      st_ff   <= st_in;
      od_ff   <= od_in;
      om_ff   <= om_in;
      oy_ff   <= oy_in;
      ost_ff  <= ost_in;
   end

endmodule

// File: tb/sv/calendar_date_adder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for calendar_date_adder_core: directed and random date items,
// predicted in-bench and compared against the rsp_ stream. Depends on cda_pkg.
module calendar_date_adder_core_tb;
   import cda_pkg::*;

   // unit code outside the defined set
   localparam logic [2:0] OpUnknown = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [14:0] amount;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        drain;     // hold this item back until all results are in
   } date_request_type;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [1:0]  status;
   } date_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;  // amount, start_day, start_month, start_year, zero fill
   logic [2:0]  req_tuser  = '0;  // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // end_day, end_month, end_year, zero fill
   logic [1:0]  rsp_tuser;        // status

   date_request_type start_dates[$];
   date_result_type  predicted_dates[$];
   logic            req_taken      = 1'b0;
   int unsigned     items_total    = 0;
   int unsigned     items_sent     = 0;
   int unsigned     items_accepted = 0;
   int unsigned     error_count    = 0;
   longint unsigned cycle_budget   = 0;
   longint unsigned cycle_limit    = 64'd50000000;
   longint unsigned cycle_count    = 0;

   calendar_date_adder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Gregorian month length; months outside 1..12 read as 0
   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2:             month_days = leap ? 29 : 28;
         4, 6, 9, 11:   month_days = 30;
         1, 3, 5, 7, 8,
         10, 12:        month_days = 31;
         default:       month_days = 0;
      endcase
   endfunction

   // expected date after adding the requested units
   function automatic date_result_type advance_date(input date_request_type rq);
      date_result_type res;
      int unsigned  d, m, y, rem, len, mult, ny, i;
      logic [1:0]   st;
      d  = rq.day;
      m  = rq.month;
      y  = rq.year;
      st = StatusOk;
      // date check comes before anything else, unknown unit included
      if (m < 1 || m > 12 || y < 1 || y > MaxYear || d < 1 || d > month_days(m, y)) begin
         res.day    = '0;
         res.month  = '0;
         res.year   = '0;
         res.status = StatusInvalid;
         return res;
      end
      case (rq.op)
         OpDay, OpWeek: begin
            rem = (rq.op == OpWeek) ? int'(rq.amount) * 7 : int'(rq.amount);
            while (rem > 0) begin
               len = month_days(m, y);
               if (d + rem <= len) begin
                  d   = d + rem;
                  rem = 0;
               end else begin
                  rem = rem - (len - d + 1);
                  d   = 1;
                  if (m == 12) begin
                     if (y >= MaxYear) begin
                        d  = 31;
                        m  = 12;
                        y  = MaxYear;
                        st = StatusOverflow;
                        break;
                     end
                     m = 1;
                     y = y + 1;
                  end else begin
                     m = m + 1;
                  end
               end
            end
         end
         OpMonth: begin
            // clamp after each single month step; earlier clamps stick
            for (i = 0; i < rq.amount; i++) begin
               if (m == 12) begin
                  if (y >= MaxYear) begin
                     d  = 31;
                     m  = 12;
                     y  = MaxYear;
                     st = StatusOverflow;
                     break;
                  end
                  m = 1;
                  y = y + 1;
               end else begin
                  m = m + 1;
               end
               len = month_days(m, y);
               if (d > len) d = len;
            end
         end
         OpYear, OpDecade, OpCentury, OpMillennium: begin
            case (rq.op)
               OpYear:    mult = 1;
               OpDecade:  mult = 10;
               OpCentury: mult = 100;
               default:   mult = 1000;
            endcase
            ny = y + int'(rq.amount) * mult;
            if (ny > MaxYear) begin
               ny = MaxYear;
               st = StatusOverflow;
            end
            y = ny;
         end
         default: ;  // unknown unit passes the date through
      endcase
      res.day    = d[4:0];
      res.month  = m[3:0];
      res.year   = y[13:0];
      res.status = st;
      return res;
   endfunction

   // queue one item and grow the timeout budget by its worst-case cost
   task automatic add_item(input logic [2:0] op, input int unsigned amount,
                           input int unsigned d, input int unsigned m,
                           input int unsigned y, input logic drain);
      date_request_type rq;
      int unsigned   work;
      rq.op     = op;
      rq.amount = amount[14:0];
      rq.day    = d[4:0];
      rq.month  = m[3:0];
      rq.year   = y[13:0];
      rq.drain  = drain;
      start_dates.push_back(rq);
      case (op)
         OpMonth: work = amount;
         OpDay:   work = amount / 28 + 2;
         OpWeek:  work = amount / 4 + 2;
         default: work = 1;
      endcase
      cycle_budget = cycle_budget + work + 16 + 300;
   endtask

   function automatic int unsigned pick_year();
      case ($urandom_range(5))
         0:       pick_year = $urandom_range(9999, 1);
         1:       pick_year = $urandom_range(9999, 9990);
         2:       pick_year = $urandom_range(20, 1);
         3:       pick_year = 400 * $urandom_range(24, 1);
         4:       pick_year = $urandom_range(9999, 8192);
         default: pick_year = 4 * $urandom_range(2499, 1);
      endcase
   endfunction

   function automatic int unsigned pick_amount();
      case ($urandom_range(19))
         0, 1, 2:          pick_amount = $urandom_range(32767);
         3, 4, 5, 6, 7:    pick_amount = $urandom_range(1023);
         default:          pick_amount = $urandom_range(40);
      endcase
   endfunction

   // stimulus, reset and end of run
   initial begin
      int unsigned n, m, y, d, len;
      logic [2:0]  op;

      // month and day rollover, leap rules, zero amount
      add_item(OpDay,        1,     31, 12, 1999, 1'b0);
      add_item(OpDay,        0,     15,  6, 2021, 1'b0);
      add_item(OpDay,        1,     28,  2, 2000, 1'b0);
      add_item(OpDay,        1,     28,  2, 1900, 1'b0);
      add_item(OpDay,        1,     28,  2, 2024, 1'b0);
      add_item(OpWeek,       1,     25, 12, 2023, 1'b0);
      add_item(OpWeek,       32767,  1,  1,    1, 1'b0);
      // month clamp, longest month run, overflow by day and month
      add_item(OpMonth,      1,     31,  1, 2023, 1'b0);
      add_item(OpMonth,      2,     31,  1, 2023, 1'b0);
      add_item(OpMonth,      32767,  1,  1,    1, 1'b0);
      add_item(OpMonth,      2,     15, 11, 9999, 1'b0);
      add_item(OpDay,        1,     31, 12, 9999, 1'b0);
      // year units, leap day kept, saturation
      add_item(OpYear,       1,     29,  2, 2024, 1'b0);
      add_item(OpDecade,     3,     10,  5, 1987, 1'b0);
      add_item(OpCentury,    7,     30,  4,  500, 1'b0);
      add_item(OpMillennium, 32767, 31, 12, 9999, 1'b0);
      add_item(OpUnknown,    12345, 17,  8, 1066, 1'b0);
      // invalid start dates, checked before the unit; last, a valid end-of-range date
      add_item(OpDay,        5,      1,  0, 2000, 1'b0);
      add_item(OpMonth,      5,      1, 15, 2000, 1'b0);
      add_item(OpYear,       5,     10,  3,    0, 1'b0);
      add_item(OpDay,        5,     10,  3, 16383, 1'b0);
      add_item(OpWeek,       5,      0,  7, 2000, 1'b0);
      add_item(OpDay,        1,     29,  2, 2023, 1'b0);
      add_item(OpUnknown,    0,     31,  4, 2000, 1'b0);
      add_item(OpDay,        0,     31, 12, 9999, 1'b0);

      // random part: mostly valid dates, some raw noise
      for (n = 0; n < 75; n++) begin
         op = $urandom_range(7) == 0 ? OpUnknown : 3'($urandom_range(6));
         if ($urandom_range(99) < 15) begin
            add_item(3'($urandom_range(7)), $urandom_range(32767), $urandom_range(31),
                     $urandom_range(15), $urandom_range(16383), n == 0 || n == 50);
         end else begin
            m   = $urandom_range(12, 1);
            y   = pick_year();
            len = month_days(m, y);
            d   = ($urandom_range(3) == 0) ? len : $urandom_range(len, 1);
            add_item(op, pick_amount(), d, m, y, n == 0 || n == 50);
         end
      end
      items_total = start_dates.size();
      cycle_limit = 4 * cycle_budget + 50000;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total) @(posedge clock);
      while (predicted_dates.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // driver: new items and ready change on the falling edge
   always @(negedge clock) begin
      date_request_type nxt;
      int unsigned   phase, send_idle, recv_idle;
      phase = (items_total == 0) ? 0 : (items_sent * 3) / items_total;
      case (phase)
         0:       begin send_idle = 29; recv_idle = 67; end
         1:       begin send_idle = 67; recv_idle = 29; end
         default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         if (req_tvalid && !req_taken) begin
            // item still waiting for acceptance
         end else if (start_dates.size() == 0 || $urandom_range(99) < send_idle ||
                      (start_dates[0].drain && predicted_dates.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            nxt = start_dates.pop_front();
            req_tdata  <= {2'b00, nxt.year, nxt.month, nxt.day, nxt.amount};
            req_tuser  <= nxt.op;
            req_tvalid <= 1'b1;
            items_sent++;
         end
      end
   end

   // monitor: results checked, accepted items predicted on the rising edge
   always @(posedge clock) begin
      date_result_type  got, want;
      date_request_type rq;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.day    = rsp_tdata[4:0];
            got.month  = rsp_tdata[8:5];
            got.year   = rsp_tdata[22:9];
            got.status = rsp_tuser;
            if (predicted_dates.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: %0d-%0d-%0d status %0d",
                           got.year, got.month, got.day, got.status);
            end else begin
               want = predicted_dates.pop_front();
               if (got.day !== want.day || got.month !== want.month ||
                   got.year !== want.year || got.status !== want.status) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: expected %0d-%0d-%0d status %0d,",
                               " got %0d-%0d-%0d status %0d"},
                              want.year, want.month, want.day, want.status,
                              got.year, got.month, got.day, got.status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq.amount = req_tdata[14:0];
            rq.day    = req_tdata[19:15];
            rq.month  = req_tdata[23:20];
            rq.year   = req_tdata[37:24];
            rq.op     = req_tuser;
            rq.drain  = 1'b0;
            predicted_dates.push_back(advance_date(rq));
            items_accepted++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
